// ----- design/cmw_pkg.sv -----
// Shared types, codes and constants of the column melt wipe offset engine.
// No dependencies; imported by the top level and the melt step unit.
package cmw_pkg;

   // slide offset of one column, signed
   typedef logic signed [9:0] offset_type;

   // step result handed from the melt step unit to the sequencer
   typedef struct packed {
      logic       moved;
      offset_type next;
   } step_result_type;

   // item modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   // configuration register indexes
   localparam int         CSR_INDEX_W      = 2;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
   localparam logic [1:0] REG_SCREEN_HGT   = 2'd1;

   // reset values of the configuration registers
   localparam logic [8:0] COLUMN_COUNT_RST = 9'd160;
   localparam logic [8:0] SCREEN_HGT_RST   = 9'd200;

   // melt constants
   localparam logic signed [10:0] FAST_LIMIT  = 11'sd16;
   localparam logic signed [10:0] SLOW_STEP   = 11'sd8;
   localparam logic signed [10:0] LOAD_WRAP   = -11'sd16;
   localparam logic signed [10:0] LOAD_FLOOR  = -11'sd15;

   // remainder of a byte by three, folding base-four digits
   function automatic logic [1:0] mod3_byte(input logic [7:0] value);
      logic [3:0] digit_sum;
      logic [2:0] fold;
      logic [2:0] rem;
      digit_sum = {2'b00, value[1:0]} + {2'b00, value[3:2]}
                + {2'b00, value[5:4]} + {2'b00, value[7:6]};
      fold = {1'b0, digit_sum[1:0]} + {1'b0, digit_sum[3:2]};
      if (fold >= 3'd6) begin
         rem = fold - 3'd6;
      end else if (fold >= 3'd3) begin
         rem = fold - 3'd3;
      end else begin
         rem = fold;
      end
      return rem[1:0];
   endfunction

endpackage

// ----- design/column_melt_wipe_offsets.sv -----
// Top level of the column melt wipe offset engine: sequencer, offset RAM,
// melt step unit. Depends on cmw_pkg, cmw_ram and cmw_melt_step.
//
// Usage: request words enter on req_* (valid/stall), one response word per
// request leaves on rsp_* (valid/stall). csr_* writes the column count
// (index 0) and screen height (index 1); csr_ready is always high; writes
// must be made while the block is idle, which the block does not enforce.
// One request is worked at a time; req_stall is high from acceptance until
// its response is loaded into the output register. The offset RAM has one
// read and one write port with registered read; the sequencer steps are:
//   load: read previous column, write new offset, reply; no operation or
//   load with no columns in use: reply; query: read column, output, reply
//   tick: per pass, each column a read state and an update state through
//   the shared melt step unit, then read column, output, reply
// A new request is taken while the previous response still waits; the
// response of that request waits in the sequencer until the output register
// is free, so a stalled receiver simply holds the block.
// Reset (synchronous) restores column count 160, height 200, load pointer
// and finished flag to zero; offsets are undefined until loaded.
module column_melt_wipe_offsets #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic [7:0]                     req_random_byte,
   input  logic [7:0]                     req_tick_count,
   input  logic [7:0]                     req_query_column,
   input  logic [7:0]                     req_query_row,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_from_end_screen,
   output logic [7:0]                     rsp_source_row,
   output logic                           rsp_finished,
   output logic signed [9:0]              rsp_column_offset,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cmw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [8:0]                     csr_data
);
   import cmw_pkg::*;

   localparam int DEPTH     = (MAX_COLUMNS > 256) ? 256 : MAX_COLUMNS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int ROW_LIMIT = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
   localparam logic [8:0] COL_CAP = 9'(DEPTH);
   localparam logic [8:0] ROW_CAP = 9'(ROW_LIMIT);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LOAD_RD = 3'd1;
   localparam logic [2:0] S_LOAD_WR = 3'd2;
   localparam logic [2:0] S_TICK_RD = 3'd3;
   localparam logic [2:0] S_TICK_WR = 3'd4;
   localparam logic [2:0] S_COL_RD  = 3'd5;
   localparam logic [2:0] S_COL_OUT = 3'd6;
   localparam logic [2:0] S_REPLY   = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [8:0]  col_count_ff, col_count_in;
   logic [8:0]  height_ff, height_in;
   logic [7:0]  load_ptr_ff, load_ptr_in;
   logic        done_ff, done_in;
   logic        moved_ff, moved_in;
   logic [7:0]  pass_ff, pass_in;
   logic [8:0]  idx_ff, idx_in;
   // captured request word
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [7:0]  col_ff, col_in;
   logic [7:0]  row_ff, row_in;
   logic [7:0]  lp_ff, lp_in;
   // staged result
   logic        res_end_ff, res_end_in;
   logic [7:0]  res_row_ff, res_row_in;
   offset_type  res_ofs_ff, res_ofs_in;
   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_end_ff, rsp_end_in;
   logic [7:0]  rsp_row_ff, rsp_row_in;
   logic        rsp_fin_ff, rsp_fin_in;
   offset_type  rsp_ofs_ff, rsp_ofs_in;

   logic [8:0]        cnt;
   logic [8:0]        hgt;
   logic [7:0]        p_eff;
   logic [7:0]        p_prev;
   logic [8:0]        p_next;
   logic              col_in_use;
   logic              req_accept;
   logic              out_free;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   offset_type        ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [9:0]        ram_rd_data;
   offset_type        rd_ofs;
   step_result_type   step;
   logic signed [10:0] load_sum;
   logic signed [10:0] rd_ext;

   // columns and rows in use
   assign cnt = (col_count_ff > COL_CAP) ? COL_CAP : col_count_ff;
   assign hgt = (height_ff > ROW_CAP) ? ROW_CAP : height_ff;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign p_eff      = ({1'b0, load_ptr_ff} >= cnt) ? 8'd0 : load_ptr_ff;
   assign p_prev     = lp_ff - 8'd1;
   assign p_next     = {1'b0, lp_ff} + 9'd1;
   assign col_in_use = ({1'b0, col_ff} < cnt);
   assign rd_ofs     = offset_type'(ram_rd_data);
   assign rd_ext     = {rd_ofs[9], rd_ofs};

   // offset store
   cmw_ram #(
      .WIDTH (10),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared melt step unit
   cmw_melt_step u_step (
      .offset (rd_ofs),
      .height (hgt),
      .result (step)
   );

   // read address select
   always_comb begin
      case (state_ff)
         S_LOAD_RD: ram_rd_addr = p_prev[ADDR_W-1:0];
         S_TICK_RD: ram_rd_addr = idx_ff[ADDR_W-1:0];
         default:   ram_rd_addr = col_ff[ADDR_W-1:0];
      endcase
   end

   // new load offset from the previous column
   always_comb begin
      load_sum = rd_ext + {9'd0, mod3_byte(rnd_ff)} - 11'sd1;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      col_count_in = col_count_ff;
      height_in    = height_ff;
      load_ptr_in  = load_ptr_ff;
      done_in      = done_ff;
      moved_in     = moved_ff;
      pass_in      = pass_ff;
      idx_in       = idx_ff;
      mode_in      = mode_ff;
      rnd_in       = rnd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lp_in        = lp_ff;
      res_end_in   = res_end_ff;
      res_row_in   = res_row_ff;
      res_ofs_in   = res_ofs_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_end_in   = rsp_end_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_ofs_in   = rsp_ofs_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff[ADDR_W-1:0];
      ram_wr_data  = step.next;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            REG_COLUMN_COUNT: col_count_in = csr_data;
            REG_SCREEN_HGT:   height_in    = csr_data;
            default:          ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_in    = req_mode;
               rnd_in     = req_random_byte;
               col_in     = req_query_column;
               row_in     = req_query_row;
               lp_in      = p_eff;
               pass_in    = req_tick_count;
               idx_in     = 9'd0;
               moved_in   = 1'b0;
               res_end_in = 1'b0;
               res_row_in = 8'd0;
               res_ofs_in = '0;
               case (req_mode)
                  MODE_LOAD: begin
                     state_in = (cnt == 9'd0) ? S_REPLY : S_LOAD_RD;
                  end
                  MODE_TICK: begin
                     if (cnt == 9'd0 || req_tick_count == 8'd0) begin
                        state_in = S_COL_RD;
                     end else begin
                        state_in = S_TICK_RD;
                     end
                  end
                  MODE_QUERY: state_in = S_COL_RD;
                  default:    state_in = S_REPLY;
               endcase
            end
         end
         S_LOAD_RD: begin
            state_in = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            if (lp_ff == 8'd0) begin
               res_ofs_in = -offset_type'({6'd0, rnd_ff[3:0]});
            end else if (load_sum > 11'sd0) begin
               res_ofs_in = '0;
            end else if (load_sum == LOAD_WRAP) begin
               res_ofs_in = LOAD_FLOOR[9:0];
            end else begin
               res_ofs_in = load_sum[9:0];
            end
            ram_wr_en   = 1'b1;
            ram_wr_addr = lp_ff[ADDR_W-1:0];
            ram_wr_data = res_ofs_in;
            load_ptr_in = (p_next >= cnt) ? 8'd0 : p_next[7:0];
            state_in    = S_REPLY;
         end
         S_TICK_RD: begin
            state_in = S_TICK_WR;
         end
         S_TICK_WR: begin
            ram_wr_en = step.moved;
            moved_in  = moved_ff || step.moved;
            if (idx_ff + 9'd1 == cnt) begin
               idx_in  = 9'd0;
               pass_in = pass_ff - 8'd1;
               state_in = (pass_ff == 8'd1) ? S_COL_RD : S_TICK_RD;
            end else begin
               idx_in   = idx_ff + 9'd1;
               state_in = S_TICK_RD;
            end
         end
         S_COL_RD: begin
            if (mode_ff == MODE_TICK) begin
               done_in = !moved_ff;
            end
            state_in = S_COL_OUT;
         end
         S_COL_OUT: begin
            if (mode_ff == MODE_QUERY) begin
               res_row_in = row_ff;
               if (col_in_use) begin
                  res_ofs_in = rd_ofs;
                  if (rd_ext >= 11'sd0) begin
                     if ({3'd0, row_ff} < rd_ext) begin
                        res_end_in = 1'b1;
                     end else begin
                        res_row_in = row_ff - rd_ofs[7:0];
                     end
                  end
               end
            end else begin
               res_ofs_in = col_in_use ? rd_ofs : '0;
            end
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_end_in   = res_end_ff;
               rsp_row_in   = res_row_ff;
               rsp_fin_in   = done_ff;
               rsp_ofs_in   = res_ofs_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_count_ff <= COLUMN_COUNT_RST;
         height_ff    <= SCREEN_HGT_RST;
         load_ptr_ff  <= 8'd0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_count_ff <= col_count_in;
         height_ff    <= height_in;
         load_ptr_ff  <= load_ptr_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      moved_ff   <= moved_in;
      pass_ff    <= pass_in;
      idx_ff     <= idx_in;
      mode_ff    <= mode_in;
      rnd_ff     <= rnd_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      lp_ff      <= lp_in;
      res_end_ff <= res_end_in;
      res_row_ff <= res_row_in;
      res_ofs_ff <= res_ofs_in;
      rsp_end_ff <= rsp_end_in;
      rsp_row_ff <= rsp_row_in;
      rsp_fin_ff <= rsp_fin_in;
      rsp_ofs_ff <= rsp_ofs_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_from_end_screen = rsp_end_ff;
   assign rsp_source_row      = rsp_row_ff;
   assign rsp_finished        = rsp_fin_ff;
   assign rsp_column_offset   = rsp_ofs_ff;

endmodule

// ----- design/cmw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-column slide offsets.
module cmw_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cmw_melt_step.sv -----
// One melt step of one column offset against the screen height.
// Depends on cmw_pkg for the offset and step result types.
module cmw_melt_step (
   input  cmw_pkg::offset_type      offset,
   input  logic [8:0]               height,
   output cmw_pkg::step_result_type result
);
   import cmw_pkg::*;

   logic signed [10:0] ofs_ext;
   logic signed [10:0] hgt_ext;
   logic signed [10:0] delta;
   logic signed [10:0] sum;

   // step 1 below zero, else offset+1 under fast limit, else slow step
   always_comb begin
      ofs_ext = {offset[9], offset};
      hgt_ext = {2'b00, height};
      delta   = (ofs_ext < FAST_LIMIT) ? ofs_ext + 11'sd1 : SLOW_STEP;
      sum     = ofs_ext + delta;
      result.moved = 1'b0;
      result.next  = offset;
      if (ofs_ext < 11'sd0) begin
         result.moved = 1'b1;
         result.next  = offset + 10'sd1;
      end else if (ofs_ext < hgt_ext) begin
         result.moved = 1'b1;
         result.next  = (sum >= hgt_ext) ? hgt_ext[9:0] : sum[9:0];
      end
   end

endmodule

// ----- sim/tb_column_melt_wipe_offsets.sv -----
// Self-checking testbench for the column melt wipe offset engine: a directed table, then
// phased random traffic, each response checked against the table or a local offset model.
// Depends on cmw_pkg and column_melt_wipe_offsets.
module tb_column_melt_wipe_offsets;
   import cmw_pkg::*;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD   = 150;
   localparam int TAIL_CYCLES = 16;
   localparam int PHASE_WORDS = 170;
   localparam int TICK_BUDGET = 2048;
   localparam int NUM_PHASES  = 10;

   // register settings per random phase, extremes included
   int phase_columns [NUM_PHASES] = '{1, 5, 0, 256, 511, 2, 33, 8, 64, 160};
   int phase_heights [NUM_PHASES] = '{1, 16, 0, 256, 511, 300, 100, 0, 255, 200};

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rnd;
      logic [7:0] ticks;
      logic [7:0] col;
      logic [7:0] row;
   } melt_word_type;

   typedef struct packed {
      logic       from_end;
      logic [7:0] src_row;
      logic       finished;
      offset_type offset;
   } melt_result_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      melt_word_type          word;
      logic [CSR_INDEX_W-1:0] index;
      logic [8:0]             data;
      logic                   known;
      melt_result_type        result;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_mode = '0;
   logic [7:0]             req_random_byte = '0;
   logic [7:0]             req_tick_count = '0;
   logic [7:0]             req_query_column = '0;
   logic [7:0]             req_query_row = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_from_end_screen;
   logic [7:0]             rsp_source_row;
   logic                   rsp_finished;
   logic signed [9:0]      rsp_column_offset;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [8:0]             csr_data = '0;

   // local copy of the engine state and registers
   int melt_offsets [MAX_COLUMNS];
   bit offset_written [MAX_COLUMNS];
   int next_column = 0;
   bit melt_done = 1'b0;
   int cfg_columns = int'(COLUMN_COUNT_RST);
   int cfg_height = int'(SCREEN_HGT_RST);

   melt_result_type  awaited_results [$];
   directed_row_type directed_rows [$];

   int mismatches = 0;
   int results_checked = 0;
   int words_sent = 0;
   int loads_sent = 0;
   int ticks_sent = 0;
   int queries_sent = 0;
   int nops_sent = 0;
   int csr_writes = 0;
   bit quiet_tail = 1'b0;
   bit long_hold_pending = 1'b0;

   column_melt_wipe_offsets #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS   (MAX_ROWS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_random_byte    (req_random_byte),
      .req_tick_count     (req_tick_count),
      .req_query_column   (req_query_column),
      .req_query_row      (req_query_row),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_from_end_screen(rsp_from_end_screen),
      .rsp_source_row     (rsp_source_row),
      .rsp_finished       (rsp_finished),
      .rsp_column_offset  (rsp_column_offset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int live_columns();
      int n;
      n = cfg_columns;
      if (n > MAX_COLUMNS) n = MAX_COLUMNS;
      if (n > 256) n = 256;
      return n;
   endfunction

   // melt engine behavior for one accepted word, updates the local state
   function automatic melt_result_type melt_predict(melt_word_type w);
      melt_result_type res;
      int cnt, hgt, p, o, dy, t, i;
      bit moved;
      res = '0;
      cnt = live_columns();
      hgt = (cfg_height > MAX_ROWS) ? MAX_ROWS : cfg_height;
      case (w.mode)
         MODE_LOAD: begin
            if (cnt > 0) begin
               p = (next_column >= cnt) ? 0 : next_column;
               if (p == 0) begin
                  o = -(int'(w.rnd) % 16);
               end else begin
                  o = melt_offsets[p - 1] + (int'(w.rnd) % 3) - 1;
                  if (o > 0) o = 0;
                  else if (o == -16) o = -15;
               end
               melt_offsets[p] = o;
               offset_written[p] = 1'b1;
               res.offset = offset_type'(o);
               p++;
               if (p >= cnt) p = 0;
               next_column = p;
            end
         end
         MODE_TICK: begin
            moved = 1'b0;
            for (t = 0; t < int'(w.ticks); t++) begin
               for (i = 0; i < cnt; i++) begin
                  o = melt_offsets[i];
                  if (o < 0) begin
                     melt_offsets[i] = o + 1;
                     moved = 1'b1;
                  end else if (o < hgt) begin
                     dy = (o < 16) ? o + 1 : 8;
                     if (o + dy >= hgt) dy = hgt - o;
                     melt_offsets[i] = o + dy;
                     moved = 1'b1;
                  end
               end
            end
            melt_done = !moved;
            if (int'(w.col) < cnt) res.offset = offset_type'(melt_offsets[w.col]);
         end
         MODE_QUERY: begin
            res.src_row = w.row;
            if (int'(w.col) < cnt) begin
               o = melt_offsets[w.col];
               res.offset = offset_type'(o);
               if (o >= 0) begin
                  if (int'(w.row) < o) res.from_end = 1'b1;
                  else res.src_row = 8'(int'(w.row) - o);
               end
            end
         end
         default: ;
      endcase
      res.finished = melt_done;
      return res;
   endfunction

   // table row builders
   function automatic directed_row_type word_row(logic [1:0] mode, int rnd, int ticks, int col,
                                                 int row);
      directed_row_type r;
      r = '0;
      r.kind = ROW_WORD;
      r.word.mode = mode;
      r.word.rnd = 8'(rnd);
      r.word.ticks = 8'(ticks);
      r.word.col = 8'(col);
      r.word.row = 8'(row);
      return r;
   endfunction

   function automatic directed_row_type checked_row(logic [1:0] mode, int rnd, int ticks,
                                                    int col, int row, int e, int srow, int fin,
                                                    int off);
      directed_row_type r;
      r = word_row(mode, rnd, ticks, col, row);
      r.known = 1'b1;
      r.result.from_end = 1'(e);
      r.result.src_row = 8'(srow);
      r.result.finished = 1'(fin);
      r.result.offset = offset_type'(off);
      return r;
   endfunction

   function automatic directed_row_type csr_row(logic [CSR_INDEX_W-1:0] idx, int value);
      directed_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.index = idx;
      r.data = 9'(value);
      return r;
   endfunction

   // offer one request word after an optional gap, predict it on acceptance
   task automatic send_word(melt_word_type w, logic known, melt_result_type typed);
      melt_result_type predicted;
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= w.mode;
      req_random_byte <= w.rnd;
      req_tick_count <= w.ticks;
      req_query_column <= w.col;
      req_query_row <= w.row;
      do @(posedge clock); while (req_stall);
      predicted = melt_predict(w);
      awaited_results.push_back(known ? typed : predicted);
      words_sent++;
      case (w.mode)
         MODE_LOAD:  loads_sent++;
         MODE_TICK:  ticks_sent++;
         MODE_QUERY: queries_sent++;
         default:    nops_sent++;
      endcase
   endtask

   // stop offering and wait for every awaited response word
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [8:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_COLUMN_COUNT) cfg_columns = int'(value);
      else if (idx == REG_SCREEN_HGT) cfg_height = int'(value);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(bit unexpected, melt_result_type want, melt_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         if (unexpected)
            $display("response %0d arrived with nothing awaited: end=%0b row=%0d fin=%0b off=%0d",
                     results_checked, got.from_end, got.src_row, got.finished, got.offset);
         else
            $display("mismatch at response %0d: expected end=%0b row=%0d fin=%0b off=%0d",
                     results_checked, want.from_end, want.src_row, want.finished, want.offset,
                     "  actual end=%0b row=%0d fin=%0b off=%0d",
                     got.from_end, got.src_row, got.finished, got.offset);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      melt_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_from_end_screen, rsp_source_row, rsp_finished, rsp_column_offset};
         results_checked++;
         if (awaited_results.size() == 0) begin
            report_mismatch(1'b1, '0, got);
         end else begin
            want = awaited_results.pop_front();
            if (got.from_end !== want.from_end || got.src_row !== want.src_row ||
                got.finished !== want.finished || got.offset !== want.offset)
               report_mismatch(1'b0, want, got);
         end
      end
   end

   // receiver: short random stall bursts, one long hold on request
   initial begin : receiver
      int burst;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("column_melt_wipe_offsets regression: fail");
      $finish;
   end

   initial begin : stimulus
      melt_word_type w;
      int ph, n, k, live, max_ticks, pick, rim_row;
      bit filled;

      // directed table: reset state, extremes, clamps, out-of-range columns, melt to done
      directed_rows.push_back(checked_row(MODE_NOP, 255, 255, 255, 255, 0, 0, 0, 0));
      directed_rows.push_back(checked_row(MODE_QUERY, 0, 0, 200, 77, 0, 77, 0, 0));
      directed_rows.push_back(checked_row(MODE_TICK, 0, 0, 255, 0, 0, 0, 1, 0));
      directed_rows.push_back(checked_row(MODE_LOAD, 255, 0, 0, 0, 0, 0, 1, -15));
      directed_rows.push_back(checked_row(MODE_LOAD, 0, 0, 0, 0, 0, 0, 1, -15));
      directed_rows.push_back(csr_row(REG_COLUMN_COUNT, 4));
      directed_rows.push_back(word_row(MODE_LOAD, 0, 0, 0, 0));
      directed_rows.push_back(word_row(MODE_LOAD, 1, 0, 0, 0));
      directed_rows.push_back(checked_row(MODE_LOAD, 16, 0, 0, 0, 0, 0, 1, 0));
      directed_rows.push_back(word_row(MODE_LOAD, 2, 0, 0, 0));
      directed_rows.push_back(word_row(MODE_LOAD, 0, 0, 0, 0));
      directed_rows.push_back(word_row(MODE_LOAD, 0, 0, 0, 0));
      directed_rows.push_back(checked_row(MODE_QUERY, 0, 0, 4, 9, 0, 9, 1, 0));
      directed_rows.push_back(word_row(MODE_QUERY, 0, 0, 3, 255));
      directed_rows.push_back(csr_row(REG_SCREEN_HGT, 16));
      directed_rows.push_back(word_row(MODE_TICK, 0, 1, 0, 0));
      directed_rows.push_back(word_row(MODE_TICK, 0, 5, 2, 0));
      directed_rows.push_back(word_row(MODE_QUERY, 0, 0, 0, 0));
      directed_rows.push_back(word_row(MODE_QUERY, 0, 0, 0, 255));
      directed_rows.push_back(word_row(MODE_TICK, 0, 255, 1, 0));
      directed_rows.push_back(word_row(MODE_TICK, 0, 1, 1, 0));
      directed_rows.push_back(word_row(MODE_QUERY, 0, 0, 1, 15));
      directed_rows.push_back(word_row(MODE_QUERY, 0, 0, 1, 16));
      directed_rows.push_back(word_row(MODE_NOP, 8'h5a, 8'ha5, 8'h3c, 8'hc3));

      // hold reset, then release it
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (k = 0; k < directed_rows.size(); k++) begin
         if (directed_rows[k].kind == ROW_CSR) begin
            drain_results();
            write_csr(directed_rows[k].index, directed_rows[k].data);
         end else begin
            send_word(directed_rows[k].word, directed_rows[k].known, directed_rows[k].result);
         end
      end

      // random phases, each under its own register setting
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results();
         if (ph == NUM_PHASES - 1) quiet_tail = 1'b1;
         write_csr(REG_COLUMN_COUNT, 9'(phase_columns[ph]));
         write_csr(REG_SCREEN_HGT, 9'(phase_heights[ph]));
         live = live_columns();

         // load every column in use that was never loaded before ticking or querying it
         do begin
            filled = 1'b1;
            for (k = 0; k < live; k++)
               if (!offset_written[k]) filled = 1'b0;
            if (!filled) begin
               w.mode = MODE_LOAD;
               w.rnd = 8'($urandom_range(0, 255));
               w.ticks = 8'($urandom_range(0, 255));
               w.col = 8'($urandom_range(0, 255));
               w.row = 8'($urandom_range(0, 255));
               send_word(w, 1'b0, '0);
            end
         end while (!filled);

         // receiver holds off for a long stretch while words keep coming
         if (ph == 1) long_hold_pending = 1'b1;

         for (n = 0; n < PHASE_WORDS; n++) begin
            w.rnd = 8'($urandom_range(0, 255));
            w.ticks = 8'($urandom_range(0, 255));
            w.col = 8'($urandom_range(0, 255));
            w.row = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
               w.mode = MODE_LOAD;
            end else if (pick < 46) begin
               // keep a tick word's column walk bounded
               w.mode = MODE_TICK;
               max_ticks = (live == 0) ? 255 : TICK_BUDGET / live;
               if (max_ticks > 255) max_ticks = 255;
               w.ticks = 8'($urandom_range(0, max_ticks));
            end else if (pick < 96) begin
               w.mode = MODE_QUERY;
            end else begin
               w.mode = MODE_NOP;
            end
            // address columns in use most of the time
            if (live > 0 && $urandom_range(0, 3) != 0) w.col = 8'($urandom_range(0, live - 1));
            // put query rows on and around the slide boundary
            if (w.mode == MODE_QUERY && int'(w.col) < live && $urandom_range(0, 2) == 0) begin
               rim_row = melt_offsets[w.col] + int'($urandom_range(0, 4)) - 2;
               if (rim_row >= 0 && rim_row <= 255) w.row = 8'(rim_row);
            end
            send_word(w, 1'b0, '0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d request words: %0d loads, %0d ticks, %0d queries, %0d no-ops",
               words_sent, loads_sent, ticks_sent, queries_sent, nops_sent);
      $display("%0d register writes over %0d settings, %0d responses checked, %0d mismatches",
               csr_writes, NUM_PHASES + 1, results_checked, mismatches);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("column_melt_wipe_offsets regression: pass");
      else
         $display("column_melt_wipe_offsets regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/cmw_pkg.sv
design/cmw_ram.sv
design/cmw_melt_step.sv
design/column_melt_wipe_offsets.sv
sim/tb_column_melt_wipe_offsets.sv
